>>> design/ternary_lut_dot_product_macros.svh
// Assertion macros shared by the ternary LUT dot product design
`ifndef TERNARY_LUT_DOT_PRODUCT_MACROS_SVH
`define TERNARY_LUT_DOT_PRODUCT_MACROS_SVH

// same-cycle implication, held off during reset
`define TLUT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlut assertion failed");

// next-cycle implication, held off during reset
`define TLUT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlut assertion failed");

`endif

>>> design/tlut_pkg.sv
// Types, constants and the combination table of the ternary LUT dot product
package tlut_pkg;

  localparam int ACC_WIDTH   = 32;
  localparam int DOT_W       = 32;
  localparam int EXT_W       = (ACC_WIDTH > DOT_W) ? ACC_WIDTH : DOT_W;
  localparam int ACT_W       = 8;
  localparam int IDX_W       = 8;
  localparam int TERM_W      = 11;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  typedef enum logic [0:0] {
    REQ_THREE = 1'b0,
    REQ_TWO   = 1'b1
  } req_type_t;

  // three-activation pattern codes
  localparam logic [IDX_W-1:0] T3_A2       = 8'd1;
  localparam logic [IDX_W-1:0] T3_A1       = 8'd2;
  localparam logic [IDX_W-1:0] T3_A0       = 8'd3;
  localparam logic [IDX_W-1:0] T3_A1PA2    = 8'd4;
  localparam logic [IDX_W-1:0] T3_A0PA2    = 8'd5;
  localparam logic [IDX_W-1:0] T3_A0PA1    = 8'd6;
  localparam logic [IDX_W-1:0] T3_A0PA1PA2 = 8'd7;
  localparam logic [IDX_W-1:0] T3_A1MA2    = 8'd8;
  localparam logic [IDX_W-1:0] T3_A0MA2    = 8'd9;
  localparam logic [IDX_W-1:0] T3_A0MA1    = 8'd10;
  localparam logic [IDX_W-1:0] T3_A0PA1MA2 = 8'd11;
  localparam logic [IDX_W-1:0] T3_A0MA1PA2 = 8'd12;
  localparam logic [IDX_W-1:0] T3_A0MA1MA2 = 8'd13;

  // two-activation pattern codes
  localparam logic [IDX_W-1:0] T2_A1    = 8'd1;
  localparam logic [IDX_W-1:0] T2_A0    = 8'd2;
  localparam logic [IDX_W-1:0] T2_A0PA1 = 8'd3;
  localparam logic [IDX_W-1:0] T2_A0MA1 = 8'd4;

  typedef struct packed {
    logic signed [TERM_W-1:0] term;
    logic                     last;
  } tlut_item_t;

  function automatic logic signed [TERM_W-1:0] pick_term(
    input req_type_t        kind,
    input logic [ACT_W-1:0] act_0,
    input logic [ACT_W-1:0] act_1,
    input logic [ACT_W-1:0] act_2,
    input logic [IDX_W-1:0] idx
  );
    logic signed [TERM_W-1:0] a0;
    logic signed [TERM_W-1:0] a1;
    logic signed [TERM_W-1:0] a2;
    logic signed [TERM_W-1:0] res;
    a0  = signed'(TERM_W'(act_0));
    a1  = signed'(TERM_W'(act_1));
    a2  = signed'(TERM_W'(act_2));
    res = '0;
    if (kind == REQ_TWO) begin
      case (idx)
        T2_A1:    res = a1;
        T2_A0:    res = a0;
        T2_A0PA1: res = a0 + a1;
        T2_A0MA1: res = a0 - a1;
        default:  res = '0;
      endcase
    end else begin
      case (idx)
        T3_A2:       res = a2;
        T3_A1:       res = a1;
        T3_A0:       res = a0;
        T3_A1PA2:    res = a1 + a2;
        T3_A0PA2:    res = a0 + a2;
        T3_A0PA1:    res = a0 + a1;
        T3_A0PA1PA2: res = a0 + a1 + a2;
        T3_A1MA2:    res = a1 - a2;
        T3_A0MA2:    res = a0 - a2;
        T3_A0MA1:    res = a0 - a1;
        T3_A0PA1MA2: res = a0 + a1 - a2;
        T3_A0MA1PA2: res = a0 - a1 + a2;
        T3_A0MA1MA2: res = a0 - a1 - a2;
        default:     res = '0;
      endcase
    end
    return res;
  endfunction

endpackage

>>> design/tlut_front.sv
// Front end: takes input transactions and turns each group into a signed term
module tlut_front (
  input  logic [tlut_pkg::IN_TDATA_W-1:0] in_tdata,  // act_0, act_1, act_2, weight_index, weight_sign
  input  logic                            in_tuser,  // req_type
  input  logic                            in_tlast,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  output tlut_pkg::tlut_item_t            item,
  output logic                            item_valid,
  input  logic                            item_ready
);
  import tlut_pkg::*;

  logic [ACT_W-1:0]         act_0;
  logic [ACT_W-1:0]         act_1;
  logic [ACT_W-1:0]         act_2;
  logic [IDX_W-1:0]         weight_index;
  logic                     weight_sign;
  logic signed [TERM_W-1:0] term_raw;

  assign act_0        = in_tdata[7:0];
  assign act_1        = in_tdata[15:8];
  assign act_2        = in_tdata[23:16];
  assign weight_index = in_tdata[31:24];
  assign weight_sign  = in_tdata[32];

  always_comb begin
    term_raw  = pick_term(req_type_t'(in_tuser), act_0, act_1, act_2, weight_index);
    item.term = weight_sign ? -term_raw : term_raw;
    item.last = in_tlast;
  end

  assign item_valid = in_tvalid;
  assign in_tready  = item_ready;

endmodule

>>> design/tlut_queue.sv
// Short FIFO of terms between the front end and the accumulator
module tlut_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tlut_pkg::tlut_item_t push_item,
  input  logic                 push_valid,
  output logic                 push_ready,
  output tlut_pkg::tlut_item_t pop_item,
  output logic                 pop_valid,
  input  logic                 pop_ready
);
  import tlut_pkg::*;

  tlut_item_t         mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = (count_r != (FIFO_AW + 1)'(FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> design/tlut_back.sv
// Back end: accumulates terms and holds the finished total for the output
`include "ternary_lut_dot_product_macros.svh"
module tlut_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tlut_pkg::tlut_item_t             item,
  input  logic                             item_valid,
  output logic                             item_ready,
  output logic [tlut_pkg::OUT_TDATA_W-1:0] out_tdata,  // dot_total
  output logic                             out_tvalid,
  input  logic                             out_tready
);
  import tlut_pkg::*;

  logic [ACC_WIDTH-1:0]    acc_r, acc_nxt;
  logic [ACC_WIDTH-1:0]    sum;
  logic signed [EXT_W-1:0] sum_ext;
  logic [DOT_W-1:0]        total_r, total_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    slot_free;
  logic                    do_pop;

  assign slot_free  = !out_valid_r || out_tready;
  assign item_ready = !item.last || slot_free;
  assign do_pop     = item_valid & item_ready;
  assign sum        = acc_r + ACC_WIDTH'(item.term);
  assign sum_ext    = EXT_W'(signed'(sum));

  always_comb begin
    acc_nxt       = acc_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (do_pop) begin
      acc_nxt = sum;
      if (item.last) begin
        acc_nxt       = '0;
        total_nxt     = sum_ext[DOT_W-1:0];
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    total_r <= total_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = total_r;

  `TLUT_ASSERT_NEXT(a_last_clears_acc, clk, rst_n, do_pop && item.last, acc_r == '0)
  `TLUT_ASSERT_NEXT(a_last_gives_result, clk, rst_n, do_pop && item.last, out_valid_r)
  `TLUT_ASSERT_SAME(a_no_overwrite, clk, rst_n, do_pop && item.last, slot_free)
  `TLUT_ASSERT_NEXT(a_plain_pop_adds, clk, rst_n, do_pop && !item.last, acc_r == $past(sum))

endmodule

>>> design/ternary_lut_dot_product.sv
// The last group passes through the queue, then the back end registers the total and out_tvalid.
// Throughput: one group per cycle while the queue has room; front end selects, back end adds.
// A 4-entry queue lets the front end keep accepting while a total waits on out_tready.
// Reset (rst_n low, synchronous): queue emptied, accumulator cleared, no output pending.
// Top level of the ternary LUT dot product
module ternary_lut_dot_product (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [tlut_pkg::IN_TDATA_W-1:0]  in_tdata,   // act_0, act_1, act_2, weight_index, weight_sign
  input  logic                             in_tuser,   // req_type
  input  logic                             in_tlast,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  output logic [tlut_pkg::OUT_TDATA_W-1:0] out_tdata,  // dot_total
  output logic                             out_tvalid,
  input  logic                             out_tready
);
  import tlut_pkg::*;

  tlut_item_t front_item;
  logic       front_valid, front_ready;
  tlut_item_t back_item;
  logic       back_valid, back_ready;

  tlut_front u_front (
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .item       (front_item),
    .item_valid (front_valid),
    .item_ready (front_ready)
  );

  tlut_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_item  (front_item),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_item   (back_item),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  tlut_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (back_item),
    .item_valid (back_valid),
    .item_ready (back_ready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

endmodule
